/* rtl/core/hrrn_pkg.sv */
`default_nettype none

package hrrn_pkg;

  // Default number of ready-table slots.
  localparam int QUEUE_DEPTH_DEFAULT = 16;

  // Fixed field widths.
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int SVC_W   = 24;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int SUM_W   = TIME_W + 1;
  localparam int PROD_W  = SUM_W + SVC_W;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED     = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_IDLE       = 2'd2,
    ST_DROPPED    = 2'd3
  } status_t;

  // Result-forming operations issued by the controller.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_DIRECT,
    RES_DROP,
    RES_QUEUE,
    RES_IGNORE,
    RES_EMPTY,
    RES_BEST
  } res_op_t;

  typedef struct packed {
    logic    capture;
    logic    mul;
    logic    cmp;
    logic    free_next;
    logic    load_out;
    res_op_t res_op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic busy;
    logic full;
    logic empty;
    logic free_here;
    logic cand_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/hrrn_ctrl.sv */
`default_nettype none

module hrrn_ctrl
  import hrrn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FREE,
    S_MUL,
    S_CMP,
    S_DISP,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.res_op = RES_NONE;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.mode) begin
          if (!stat.busy) begin
            cmd.res_op = RES_DIRECT;
            state_next = S_OUT;
          end else if (stat.full) begin
            cmd.res_op = RES_DROP;
            state_next = S_OUT;
          end else begin
            state_next = S_FREE;
          end
        end else begin
          if (!stat.busy) begin
            cmd.res_op = RES_IGNORE;
            state_next = S_OUT;
          end else if (stat.empty) begin
            cmd.res_op = RES_EMPTY;
            state_next = S_OUT;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_FREE: begin
        if (stat.free_here) begin
          cmd.res_op = RES_QUEUE;
          state_next = S_OUT;
        end else begin
          cmd.free_next = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = stat.cand_last ? S_DISP : S_MUL;
      end
      S_DISP: begin
        cmd.res_op = RES_BEST;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hrrn_dp.sv */
`default_nettype none

module hrrn_dp
  import hrrn_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         cmd,
  output dp_stat_t               stat,
  input  wire logic              mode,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic [ID_W-1:0]   job_id,
  input  wire logic [SVC_W-1:0]  service_ticks,
  output logic [STAT_W-1:0]      status,
  output logic [ID_W-1:0]        run_id,
  output logic [TIME_W-1:0]      finish_time,
  output logic [TIME_W-1:0]      turnaround,
  output logic [COUNT_W-1:0]     waiting_count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Captured input item.
  logic              cur_mode;
  logic [TIME_W-1:0] cur_now;
  logic [ID_W-1:0]   cur_id;
  logic [SVC_W-1:0]  cur_svc;

  // Scheduler state.
  logic [QUEUE_DEPTH-1:0] valid;
  logic                   busy;
  logic [TIME_W-1:0]      run_arr;
  logic [CNT_W-1:0]       count;
  logic [TIME_W-1:0]      order_counter;
  logic [IDX_W-1:0]       scan_idx;

  // Slot memories, one registered read port at scan_idx.
  logic [ID_W-1:0]   mem_job   [QUEUE_DEPTH];
  logic [TIME_W-1:0] mem_arr   [QUEUE_DEPTH];
  logic [SVC_W-1:0]  mem_svc   [QUEUE_DEPTH];
  logic [TIME_W-1:0] mem_order [QUEUE_DEPTH];
  logic [ID_W-1:0]   rd_job;
  logic [TIME_W-1:0] rd_arr;
  logic [SVC_W-1:0]  rd_svc;
  logic [TIME_W-1:0] rd_order;

  // Candidate stage.
  logic [IDX_W-1:0]  cand_idx;
  logic              cand_valid;
  logic              cand_last;
  logic [ID_W-1:0]   cand_job;
  logic [TIME_W-1:0] cand_arr;
  logic [SVC_W-1:0]  cand_svc;
  logic [SUM_W-1:0]  cand_sum;
  logic [TIME_W-1:0] cand_age;
  logic [PROD_W-1:0] prod_c;
  logic [PROD_W-1:0] prod_b;

  // Best slot so far.
  logic              have_best;
  logic [IDX_W-1:0]  best_idx;
  logic [ID_W-1:0]   best_job;
  logic [TIME_W-1:0] best_arr;
  logic [SVC_W-1:0]  best_svc;
  logic [SUM_W-1:0]  best_sum;
  logic [TIME_W-1:0] best_age;

  // Pending result.
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [TIME_W-1:0] res_finish;
  logic [TIME_W-1:0] res_turn;

  logic [TIME_W-1:0] wait_now;
  logic [SUM_W-1:0]  sum_now;
  logic [IDX_W-1:0]  idx_inc;
  logic              cand_wins;

  // Response ratio numerator (wait + service) for the slot just read. The wait
  // wraps at the time width before it is extended.
  assign wait_now = cur_now - rd_arr;
  assign sum_now  = {1'b0, wait_now} + {{(SUM_W-SVC_W){1'b0}}, rd_svc};
  assign idx_inc  = (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;

  assign cand_wins = cand_valid &&
                     (!have_best || (prod_c > prod_b) ||
                      ((prod_c == prod_b) && (cand_age > best_age)));

  assign stat.mode      = cur_mode;
  assign stat.busy      = busy;
  assign stat.full      = (count == FULL_CNT);
  assign stat.empty     = (count == '0);
  assign stat.free_here = !valid[scan_idx];
  assign stat.cand_last = cand_last;

  always_ff @(posedge clk) begin
    rd_job   <= mem_job[scan_idx];
    rd_arr   <= mem_arr[scan_idx];
    rd_svc   <= mem_svc[scan_idx];
    rd_order <= mem_order[scan_idx];
    if (cmd.res_op == RES_QUEUE) begin
      mem_job[scan_idx]   <= cur_id;
      mem_arr[scan_idx]   <= cur_now;
      mem_svc[scan_idx]   <= cur_svc;
      mem_order[scan_idx] <= order_counter;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      busy          <= 1'b0;
      run_arr       <= '0;
      count         <= '0;
      order_counter <= '0;
      scan_idx      <= '0;
      have_best     <= 1'b0;
      cand_valid    <= 1'b0;
      cand_last     <= 1'b0;
    end else begin
      if (cmd.free_next || cmd.mul) begin
        scan_idx <= idx_inc;
      end
      if (cmd.mul) begin
        cand_valid <= valid[scan_idx];
        cand_last  <= (scan_idx == LAST_IDX);
      end
      if (cmd.cmp && cand_wins) begin
        have_best <= 1'b1;
      end
      unique case (cmd.res_op)
        RES_DIRECT: begin
          busy    <= 1'b1;
          run_arr <= cur_now;
        end
        RES_QUEUE: begin
          valid[scan_idx] <= 1'b1;
          order_counter   <= order_counter + 1'b1;
          count           <= count + 1'b1;
          scan_idx        <= '0;
        end
        RES_EMPTY: begin
          busy <= 1'b0;
        end
        RES_BEST: begin
          valid[best_idx] <= 1'b0;
          count           <= count - 1'b1;
          run_arr         <= best_arr;
          have_best       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_mode <= mode;
      cur_now  <= now;
      cur_id   <= job_id;
      cur_svc  <= service_ticks;
    end
    if (cmd.mul) begin
      cand_idx <= scan_idx;
      cand_job <= rd_job;
      cand_arr <= rd_arr;
      cand_svc <= rd_svc;
      cand_sum <= sum_now;
      cand_age <= order_counter - rd_order;
      prod_c   <= PROD_W'(sum_now) * PROD_W'(best_svc);
      prod_b   <= PROD_W'(best_sum) * PROD_W'(rd_svc);
    end
    if (cmd.cmp && cand_wins) begin
      best_idx <= cand_idx;
      best_job <= cand_job;
      best_arr <= cand_arr;
      best_svc <= cand_svc;
      best_sum <= cand_sum;
      best_age <= cand_age;
    end
    unique case (cmd.res_op)
      RES_DIRECT: begin
        res_status <= ST_DISPATCHED;
        res_id     <= cur_id;
        res_finish <= cur_now + TIME_W'(cur_svc);
        res_turn   <= '0;
      end
      RES_DROP: begin
        res_status <= ST_DROPPED;
        res_id     <= '0;
        res_finish <= '0;
        res_turn   <= '0;
      end
      RES_QUEUE: begin
        res_status <= ST_QUEUED;
        res_id     <= '0;
        res_finish <= '0;
        res_turn   <= '0;
      end
      RES_IGNORE: begin
        res_status <= ST_IDLE;
        res_id     <= '0;
        res_finish <= '0;
        res_turn   <= '0;
      end
      RES_EMPTY: begin
        res_status <= ST_IDLE;
        res_id     <= '0;
        res_finish <= '0;
        res_turn   <= cur_now - run_arr;
      end
      RES_BEST: begin
        res_status <= ST_DISPATCHED;
        res_id     <= best_job;
        res_finish <= cur_now + TIME_W'(best_svc);
        res_turn   <= cur_now - run_arr;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      status        <= res_status;
      run_id        <= res_id;
      finish_time   <= res_finish;
      turnaround    <= res_turn;
      waiting_count <= COUNT_W'(count);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hrrn_job_scheduler.sv */
// Arrivals go straight to a result when the server is idle or the table is full;
// queued arrivals first search for a free slot, one slot a cycle.
// Completions with waiting jobs scan the ready table with a multiply step and
// then a compare step per slot.
// Synchronous active-high reset empties the ready table, idles the server and
// clears the order counter; the block accepts a transfer in the cycle after reset.
`default_nettype none

module hrrn_job_scheduler
  import hrrn_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              mode,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic [ID_W-1:0]   job_id,
  input  wire logic [SVC_W-1:0]  service_ticks,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      status,
  output logic [ID_W-1:0]        run_id,
  output logic [TIME_W-1:0]      finish_time,
  output logic [TIME_W-1:0]      turnaround,
  output logic [COUNT_W-1:0]     waiting_count
);

  // The controller sequences each event: it decides the case from the captured
  // event and the server state, walks the table for a free slot on a queued
  // arrival, or walks every slot on a completion, and then places the result in
  // the output register. The output register holds the previous result until its
  // transfer completes, so a new event is taken while a result still waits.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  hrrn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the slot memories, the valid bits, and the ratio unit.
  // Ratios are compared exactly: the candidate wins when its (wait + service)
  // times the best job's service exceeds the best job's (wait + service) times
  // its own service. Equal products go to the job queued earlier.
  hrrn_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .now           (now),
    .job_id        (job_id),
    .service_ticks (service_ticks),
    .status        (status),
    .run_id        (run_id),
    .finish_time   (finish_time),
    .turnaround    (turnaround),
    .waiting_count (waiting_count)
  );

endmodule

`default_nettype wire

/* rtl/core/hrrn_checker.sv */
`default_nettype none

module hrrn_checker
  import hrrn_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              mode,
  input wire logic [TIME_W-1:0] now,
  input wire logic [ID_W-1:0]   job_id,
  input wire logic [SVC_W-1:0]  service_ticks,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [STAT_W-1:0] status,
  input wire logic [ID_W-1:0]   run_id,
  input wire logic [TIME_W-1:0] finish_time,
  input wire logic [TIME_W-1:0] turnaround,
  input wire logic [COUNT_W-1:0] waiting_count
);

  // A stalled event keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(now) &&
      $stable(job_id) && $stable(service_ticks))
    else $error("event changed while stalled");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(run_id) &&
      $stable(finish_time) && $stable(turnaround) && $stable(waiting_count))
    else $error("result changed while stalled");

  // Only a dispatch carries a job id and a finish time.
  a_no_dispatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DISPATCHED) |-> (run_id == '0) && (finish_time == '0))
    else $error("non-dispatch result carries job fields");

  // Arrivals that do not start a job report no turnaround.
  a_arrival_turn: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_QUEUED) || (status == ST_DROPPED)) |-> turnaround == '0)
    else $error("arrival reported a turnaround");

  // The server only goes idle with an empty ready table.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_IDLE) |-> waiting_count == '0)
    else $error("server idle with jobs waiting");

endmodule

bind hrrn_job_scheduler hrrn_checker u_hrrn_checker (.*);

`default_nettype wire
